FILE: rtl/sit_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the segment intersection test core
// no dependencies

package sit_pkg;

    // width of the collinearity tolerance register
    localparam int TOL_BITS = 33;

    // result byte width on the master side
    localparam int RESULT_BYTES_W = 8;

    // classification of one orientation determinant
    typedef struct packed {
        logic zero;   // magnitude within tolerance, collinear
        logic neg;    // sign of the determinant, meaningful when zero is low
    } orient_class_t;

    // true when two classes differ (zero, positive and negative are distinct)
    function automatic logic class_differs(input orient_class_t a, input orient_class_t b);
        class_differs = (a.zero != b.zero) || (!a.zero && (a.neg != b.neg));
    endfunction

endpackage

FILE: rtl/sit_orient.sv
`timescale 1ns / 1ps
// one orientation determinant: registered products, then registered class
// depends on sit_pkg

module sit_orient import sit_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         prod_en,
    input  logic                         cls_en,
    input  logic signed [COORD_BITS-1:0] p0x,
    input  logic signed [COORD_BITS-1:0] p0y,
    input  logic signed [COORD_BITS-1:0] p1x,
    input  logic signed [COORD_BITS-1:0] p1y,
    input  logic signed [COORD_BITS-1:0] p2x,
    input  logic signed [COORD_BITS-1:0] p2y,
    input  logic        [TOL_BITS-1:0]   tolerance,
    output orient_class_t                cls_reg
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * COORD_BITS + 2;
    localparam int DET_W  = 2 * COORD_BITS + 3;
    localparam int CMP_W  = (DET_W > TOL_BITS) ? DET_W : TOL_BITS;

    logic signed [DIFF_W-1:0] ux, uy, vx, vy;
    logic signed [PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic signed [PROD_W-1:0] prod_a_next, prod_b_next;
    logic signed [DET_W-1:0]  det;
    logic        [DET_W-1:0]  mag;
    orient_class_t            cls_next;

    // edge vectors p0->p1 and p1->p2
    assign ux = DIFF_W'(p1x) - DIFF_W'(p0x);
    assign uy = DIFF_W'(p1y) - DIFF_W'(p0y);
    assign vx = DIFF_W'(p2x) - DIFF_W'(p1x);
    assign vy = DIFF_W'(p2y) - DIFF_W'(p1y);

    assign prod_a_next = PROD_W'(ux) * PROD_W'(vy);
    assign prod_b_next = PROD_W'(vx) * PROD_W'(uy);

    always_ff @(posedge aclk) begin
        if (prod_en) begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
    end

    assign det = DET_W'(prod_a_reg) - DET_W'(prod_b_reg);
    assign mag = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);

    always_comb begin
        cls_next.zero = CMP_W'(mag) <= CMP_W'(tolerance);
        cls_next.neg  = det[DET_W-1];
    end

    always_ff @(posedge aclk) begin
        if (cls_en) begin
            cls_reg <= cls_next;
        end
    end

endmodule

FILE: rtl/segment_intersection_test_core.sv
`timescale 1ns / 1ps
// top level of the segment intersection test: stream ports, pipeline control,
// decision logic; depends on sit_pkg and sit_orient
//
// usage
//   s_axis carries one query per transaction: two segments A-B and C-D as
//   eight signed coordinates ax, ay, bx, by, cx, cy, dx, dy, COORD_BITS each
//   m_axis returns one byte per query, bit 0 is intersects (1 = touch or cross)
//   cfg_we / cfg_wdata write the 33-bit collinearity tolerance; write it only
//   while no query is in flight
// timing
//   four-stage pipeline: input register, product registers, class registers,
//   result register; a query accepted on s_axis passes these in that order
//   and is held on m_axis until the receiver takes it
//   one query per cycle sustained while m_axis_tready stays high; the product
//   stage holds eight multipliers, one pair per determinant
// reset
//   aresetn low empties the pipeline and clears the tolerance to zero
// backpressure
//   each stage advances when it is empty or the next stage moves, so bubbles
//   fill up while m_axis_tready is low; s_axis_tready drops only when all four
//   stages hold data and the result is not taken

module segment_intersection_test_core import sit_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // config write port
    input  logic                      cfg_we,
    input  logic [TOL_BITS-1:0]       cfg_wdata,     // zero_tolerance
    // query input
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [8*COORD_BITS-1:0]   s_axis_tdata,  // ax, ay, bx, by, cx, cy, dx, dy
    // result output
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [RESULT_BYTES_W-1:0] m_axis_tdata   // intersects, then zero padding
);

    localparam int CB = COORD_BITS;

    // tolerance register
    logic [TOL_BITS-1:0] tol_reg;

    // pipeline valids and stage enables
    logic v0_reg, v1_reg, v2_reg, m_valid_reg;
    logic en0, en1, en2, en3;

    // payload
    logic [8*CB-1:0]     coord_reg;
    logic                end_eq1_reg, end_eq2_reg;
    logic                end_eq_next;
    logic                intersects_reg, intersects_next;

    logic signed [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    orient_class_t        cls_abc, cls_abd, cls_cda, cls_cdb;

    // a stage moves when it is empty or the one after it moves
    assign en3 = !m_valid_reg || m_axis_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;

    assign s_axis_tready = en0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg     <= '0;
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
            if (en0) v0_reg      <= s_axis_tvalid;
            if (en1) v1_reg      <= v0_reg;
            if (en2) v2_reg      <= v1_reg;
            if (en3) m_valid_reg <= v2_reg;
        end
    end

    // input register, loaded on each accepted transaction
    always_ff @(posedge aclk) begin
        if (en0 && s_axis_tvalid) begin
            coord_reg <= s_axis_tdata;
        end
    end

    assign ax = coord_reg[0*CB +: CB];
    assign ay = coord_reg[1*CB +: CB];
    assign bx = coord_reg[2*CB +: CB];
    assign by = coord_reg[3*CB +: CB];
    assign cx = coord_reg[4*CB +: CB];
    assign cy = coord_reg[5*CB +: CB];
    assign dx = coord_reg[6*CB +: CB];
    assign dy = coord_reg[7*CB +: CB];

    // shared endpoint check, carried alongside the determinants
    assign end_eq_next = ((ax == cx) && (ay == cy)) || ((ax == dx) && (ay == dy)) ||
                         ((bx == cx) && (by == cy)) || ((bx == dx) && (by == dy));

    always_ff @(posedge aclk) begin
        if (en1) end_eq1_reg <= end_eq_next;
        if (en2) end_eq2_reg <= end_eq1_reg;
    end

    // the four orientation determinants: (A,B,C), (A,B,D), (C,D,A), (C,D,B)
    sit_orient #(.COORD_BITS(CB)) u_orient_abc (
        .aclk(aclk), .prod_en(en1), .cls_en(en2),
        .p0x(ax), .p0y(ay), .p1x(bx), .p1y(by), .p2x(cx), .p2y(cy),
        .tolerance(tol_reg), .cls_reg(cls_abc)
    );

    sit_orient #(.COORD_BITS(CB)) u_orient_abd (
        .aclk(aclk), .prod_en(en1), .cls_en(en2),
        .p0x(ax), .p0y(ay), .p1x(bx), .p1y(by), .p2x(dx), .p2y(dy),
        .tolerance(tol_reg), .cls_reg(cls_abd)
    );

    sit_orient #(.COORD_BITS(CB)) u_orient_cda (
        .aclk(aclk), .prod_en(en1), .cls_en(en2),
        .p0x(cx), .p0y(cy), .p1x(dx), .p1y(dy), .p2x(ax), .p2y(ay),
        .tolerance(tol_reg), .cls_reg(cls_cda)
    );

    sit_orient #(.COORD_BITS(CB)) u_orient_cdb (
        .aclk(aclk), .prod_en(en1), .cls_en(en2),
        .p0x(cx), .p0y(cy), .p1x(dx), .p1y(dy), .p2x(bx), .p2y(by),
        .tolerance(tol_reg), .cls_reg(cls_cdb)
    );

    // decision, order matters
    always_comb begin
        priority if (cls_abc.zero && cls_abd.zero) begin
            // both ends of CD on line AB: only a shared endpoint counts
            intersects_next = end_eq2_reg;
        end else if (cls_abc.zero || cls_abd.zero) begin
            // one end of CD on line AB: A and B must fall on different classes
            intersects_next = class_differs(cls_cda, cls_cdb);
        end else if (cls_cda.zero || cls_cdb.zero) begin
            // an end of AB on line CD
            intersects_next = class_differs(cls_abc, cls_abd);
        end else begin
            // general position: each segment splits the other
            intersects_next = class_differs(cls_abc, cls_abd) &&
                              class_differs(cls_cda, cls_cdb);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (en3) begin
            intersects_reg <= intersects_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(RESULT_BYTES_W-1){1'b0}}, intersects_reg};

endmodule

FILE: rtl/sit_checker.sv
`timescale 1ns / 1ps
// port-level checks for segment_intersection_test_core, attached by bind
// depends on sit_pkg

module sit_checker import sit_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [RESULT_BYTES_W-1:0] m_axis_tdata
);

    // reset leaves the pipeline empty and ready
    a_reset_empty: assert property (@(posedge aclk)
        !$past(aresetn) |-> (!m_axis_tvalid && s_axis_tready))
        else $error("pipeline not empty after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // padding above the result bit stays clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[RESULT_BYTES_W-1:1] == '0))
        else $error("result padding not zero");

    // input side only stalls while the result side is stalled
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

endmodule

bind segment_intersection_test_core sit_checker u_sit_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for segment_intersection_test_core: directed and random segment
// pairs under several collinearity tolerances, each answer predicted and compared in order
// depends on sit_pkg and the core rtl only

module testbench;
    import sit_pkg::*;

    localparam int COORD_BITS  = 16;
    localparam int CYCLE_LIMIT = 200000;  // generous, slowest legal run is far below
    localparam int DRAIN_WAIT  = 8;       // pipeline is four stages deep
    localparam int HOLD_CYCLES = 48;      // long receiver hold-off, fills the pipeline

    // orientation class of one determinant
    typedef enum logic [1:0] {
        ORIENT_NEG,
        ORIENT_ZERO,
        ORIENT_POS
    } orient_t;

    // kinds of random query, spread so the decision branches all get exercised
    typedef enum int {
        GEN_UNIFORM,
        GEN_SMALL_BOX,
        GEN_EDGE_VALUES,
        GEN_SHARED_END,
        GEN_COLLINEAR,
        GEN_NEAR_COLLINEAR,
        GEN_CROSSING
    } query_kind_t;

    // in-order intersection checker: holds the tolerance and the expected answers
    class intersect_scoreboard;
        logic [TOL_BITS-1:0] tolerance;
        bit                  expected_hits[$];
        int                  errors;
        int                  results_seen;

        function new();
            tolerance    = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        task report_mismatch(input string what, input int got, input int want);
            $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
                     $realtime, what, results_seen, got, want);
            errors++;
        endtask

        // classify one orientation determinant against the tolerance
        function orient_t classify(input longint x0, input longint y0, input longint x1,
                                   input longint y1, input longint x2, input longint y2);
            longint det;
            longint mag;
            longint tol;
            det = (x1 - x0) * (y2 - y1) - (x2 - x1) * (y1 - y0);
            mag = (det < 0) ? -det : det;
            tol = tolerance;  // zero-extended
            if (mag <= tol)
                return ORIENT_ZERO;
            return (det < 0) ? ORIENT_NEG : ORIENT_POS;
        endfunction

        // work out the answer for one accepted query and queue it
        function void note_query(input logic [8*COORD_BITS-1:0] query);
            longint  pt[8];
            shortint coord;
            orient_t o_abc, o_abd, o_cda, o_cdb;
            bit      hit;
            for (int i = 0; i < 8; i++) begin
                coord = query[COORD_BITS*i +: COORD_BITS];
                pt[i] = coord;
            end
            // pt: 0 ax, 1 ay, 2 bx, 3 by, 4 cx, 5 cy, 6 dx, 7 dy
            o_abc = classify(pt[0], pt[1], pt[2], pt[3], pt[4], pt[5]);
            o_abd = classify(pt[0], pt[1], pt[2], pt[3], pt[6], pt[7]);
            o_cda = classify(pt[4], pt[5], pt[6], pt[7], pt[0], pt[1]);
            o_cdb = classify(pt[4], pt[5], pt[6], pt[7], pt[2], pt[3]);
            if (o_abc == ORIENT_ZERO && o_abd == ORIENT_ZERO) begin
                // both ends of cd on line ab: only a shared endpoint counts
                hit = (pt[0] == pt[4] && pt[1] == pt[5]) || (pt[0] == pt[6] && pt[1] == pt[7]) ||
                      (pt[2] == pt[4] && pt[3] == pt[5]) || (pt[2] == pt[6] && pt[3] == pt[7]);
            end else if (o_abc == ORIENT_ZERO || o_abd == ORIENT_ZERO) begin
                hit = (o_cda != o_cdb);
            end else if (o_cda == ORIENT_ZERO || o_cdb == ORIENT_ZERO) begin
                hit = (o_abc != o_abd);
            end else begin
                hit = (o_abc != o_abd) && (o_cda != o_cdb);
            end
            expected_hits.push_back(hit);
        endfunction

        // compare one accepted result with the oldest expectation
        task check_result(input logic [RESULT_BYTES_W-1:0] result);
            bit want;
            results_seen++;
            if (expected_hits.size() == 0) begin
                report_mismatch("unexpected result", int'(result[0]), -1);
            end else begin
                want = expected_hits.pop_front();
                if (result[0] !== want)
                    report_mismatch("intersects", int'(result[0]), int'(want));
                if (result[RESULT_BYTES_W-1:1] !== '0)
                    report_mismatch("padding", int'(result[RESULT_BYTES_W-1:1]), 0);
            end
        endtask
    endclass

    // dut signals
    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [TOL_BITS-1:0]       cfg_wdata;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [8*COORD_BITS-1:0]   s_axis_tdata;   // ax, ay, bx, by, cx, cy, dx, dy
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [RESULT_BYTES_W-1:0] m_axis_tdata;   // intersects, then zero padding

    // stimulus control shared with the receiver process
    bit idle_on;        // random idle bursts allowed on both sides
    bit hold_request;   // ask the receiver for one long hold-off
    int cycle_count = 0;

    intersect_scoreboard sb;

    segment_intersection_test_core #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog, ends a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // monitor: both channels sampled at the rising edge, one transaction per handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_query(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // receiver: short random stalls, plus a long hold-off on request so the
    // pipeline backs up and the input side has to stall
    initial begin
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // pack eight coordinates, ax in the lowest bits
    function automatic logic [8*COORD_BITS-1:0] pack_query(
        input int ax, input int ay, input int bx, input int by,
        input int cx, input int cy, input int dx, input int dy);
        logic [COORD_BITS-1:0] c[8];
        logic [8*COORD_BITS-1:0] q;
        c = '{ax[COORD_BITS-1:0], ay[COORD_BITS-1:0], bx[COORD_BITS-1:0], by[COORD_BITS-1:0],
              cx[COORD_BITS-1:0], cy[COORD_BITS-1:0], dx[COORD_BITS-1:0], dy[COORD_BITS-1:0]};
        for (int i = 0; i < 8; i++)
            q[COORD_BITS*i +: COORD_BITS] = c[i];
        return q;
    endfunction

    // a coordinate from the corners of the range and around zero
    function automatic int edge_coord();
        case ($urandom_range(0, 6))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            default: return 32767;
        endcase
    endfunction

    function automatic int rand_coord(input int lo, input int hi);
        return int'($urandom_range(hi - lo, 0)) + lo;
    endfunction

    // one random query; well-formed geometric cases dominate, uniform ones are noise
    function automatic logic [8*COORD_BITS-1:0] random_query();
        int p[8];
        int base_x, base_y, dir_x, dir_y, m0, m1, m2, m3;
        int mid_x, mid_y, ux, uy, vx, vy, src;
        query_kind_t kind;
        kind = query_kind_t'($urandom_range(0, 6));
        case (kind)
            GEN_UNIFORM: begin
                for (int i = 0; i < 8; i++)
                    p[i] = rand_coord(-32768, 32767);
            end
            GEN_SMALL_BOX: begin
                for (int i = 0; i < 8; i++)
                    p[i] = rand_coord(-4, 4);
            end
            GEN_EDGE_VALUES: begin
                for (int i = 0; i < 8; i++)
                    p[i] = edge_coord();
            end
            GEN_SHARED_END: begin
                for (int i = 0; i < 8; i++)
                    p[i] = ($urandom_range(0, 1) != 0) ? rand_coord(-32768, 32767)
                                                       : rand_coord(-20, 20);
                // copy an end of ab onto an end of cd
                src = 2 * $urandom_range(0, 1);
                if ($urandom_range(0, 1) != 0) begin
                    p[4] = p[src];
                    p[5] = p[src + 1];
                end else begin
                    p[6] = p[src];
                    p[7] = p[src + 1];
                end
            end
            GEN_COLLINEAR, GEN_NEAR_COLLINEAR: begin
                // four points on one line, some equal, some overlapping
                base_x = rand_coord(-1000, 1000);
                base_y = rand_coord(-1000, 1000);
                dir_x  = rand_coord(-100, 100);
                dir_y  = rand_coord(-100, 100);
                m0 = rand_coord(-300, 300);
                m1 = rand_coord(-300, 300);
                m2 = ($urandom_range(0, 3) == 0) ? m0 : rand_coord(-300, 300);
                m3 = ($urandom_range(0, 3) == 0) ? m1 : rand_coord(-300, 300);
                p = '{base_x + m0 * dir_x, base_y + m0 * dir_y, base_x + m1 * dir_x,
                      base_y + m1 * dir_y, base_x + m2 * dir_x, base_y + m2 * dir_y,
                      base_x + m3 * dir_x, base_y + m3 * dir_y};
                if (kind == GEN_NEAR_COLLINEAR) begin
                    // nudge so the determinant is small, possibly still zero
                    p[$urandom_range(0, 7)] += rand_coord(-3, 3);
                    p[$urandom_range(0, 7)] += rand_coord(-3, 3);
                end
            end
            default: begin
                // both segments around a common midpoint, mostly crossing
                mid_x = rand_coord(-16000, 16000);
                mid_y = rand_coord(-16000, 16000);
                ux = rand_coord(-16000, 16000);
                uy = rand_coord(-16000, 16000);
                vx = rand_coord(-16000, 16000);
                vy = rand_coord(-16000, 16000);
                p = '{mid_x - ux, mid_y - uy, mid_x + ux, mid_y + uy,
                      mid_x - vx, mid_y - vy, mid_x + vx, mid_y + vy};
                if ($urandom_range(0, 3) == 0)
                    p[$urandom_range(4, 7)] += rand_coord(-50, 50);
            end
        endcase
        return pack_query(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
    endfunction

    // offer one query and hold it until the core takes it; entered and left at a falling edge
    task automatic send_query(input logic [8*COORD_BITS-1:0] query);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= query;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // write the tolerance register, only while nothing is in flight
    task automatic write_tolerance(input logic [TOL_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.tolerance = value;
    endtask

    // stop offering and wait for every outstanding answer
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // one random phase at a given tolerance
    task automatic run_random_phase(input logic [TOL_BITS-1:0] tol, input int count,
                                    input bit allow_idle, input bit with_hold);
        write_tolerance(tol);
        idle_on = allow_idle;
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == count / 3)
                hold_request = 1'b1;
            send_query(random_query());
        end
        wait_drained();
    endtask

    // main sequence
    initial begin
        sb            = new();
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed cases at the reset tolerance of zero
        send_query(pack_query(-10, -10, 10, 10, -10, 10, 10, -10));   // plain crossing
        send_query(pack_query(0, 0, 10, 0, 0, 5, 10, 5));             // parallel, apart
        send_query(pack_query(0, 0, 10, 0, 2, 0, 8, 0));              // collinear overlap, no shared end
        send_query(pack_query(0, 0, 10, 0, 10, 0, 20, 0));            // collinear, shared end
        send_query(pack_query(0, 0, 10, 0, 20, 0, 30, 0));            // collinear, apart
        send_query(pack_query(0, 0, 10, 0, 5, 0, 5, 7));              // c on ab, t junction
        send_query(pack_query(0, 0, 10, 0, 15, 0, 15, 7));            // c on line ab, off segment
        send_query(pack_query(5, 0, 5, 7, 0, 0, 10, 0));              // a on cd
        send_query(pack_query(15, 0, 15, 7, 0, 0, 10, 0));            // a on line cd, off segment
        send_query(pack_query(5, 0, 5, 0, 0, 0, 10, 0));              // point inside a segment
        send_query(pack_query(0, 0, 0, 0, 0, 0, 10, 0));              // point on an end
        send_query(pack_query(3, 3, 3, 3, 3, 3, 3, 3));               // equal points
        send_query(pack_query(1, 1, 1, 1, 2, 2, 2, 2));               // distinct points
        send_query(pack_query(-32768, -32768, -32768, -32768,
                              -32768, -32768, -32768, -32768));       // all minimum
        send_query(pack_query(32767, 32767, 32767, 32767,
                              32767, 32767, 32767, 32767));           // all maximum
        send_query(pack_query(-32768, -32768, 32767, 32767,
                              -32768, 32767, 32767, -32768));         // largest determinants
        send_query(pack_query(-32768, -32768, 32767, -32768,
                              -32768, 32767, 32767, 32767));          // range-wide parallels
        send_query(pack_query(0, 0, 1000, 0, 2000, 1, 3000, -1));     // nearly collinear
        send_query(pack_query(0, 0, 10, 10, 10, 10, 20, 0));          // ends touch at an angle
        send_query(pack_query(-1, -1, 0, 0, -1, 0, 0, -1));           // sign boundary crossing
        wait_drained();

        // random phases across the tolerance range, each with one long hold-off
        run_random_phase('0, 250, 1'b1, 1'b1);
        run_random_phase(TOL_BITS'($urandom_range(1, 100000)), 200, 1'b1, 1'b1);
        run_random_phase({1'($urandom_range(0, 1)), 32'($urandom)}, 200, 1'b1, 1'b1);
        run_random_phase({TOL_BITS{1'b1}}, 150, 1'b1, 1'b1);
        // last stretch at full rate on both sides
        run_random_phase('0, 300, 1'b0, 1'b0);

        repeat (DRAIN_WAIT) @(negedge aclk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
